// ===== rtl/core/adm_pkg.sv =====
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types and constants for the averaging decimator with downmix.
// ----------------------------------------------------------------------------
package adm_pkg;

    // payload and register widths
    localparam int SAMPLE_W         = 16;
    localparam int CFG_W            = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int MAX_CHANNELS_DEF = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DIVIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MONO        = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RATE_RESET  = 4'd1;
    localparam logic [CFG_W-1:0] CHAN_RESET  = 4'd2;

    // divider codes that take effect
    localparam logic [CFG_W-1:0] RATE_DIV2 = 4'd2;
    localparam logic [CFG_W-1:0] RATE_DIV4 = 4'd4;

    // output channel codes
    localparam logic CHAN_LEFT  = 1'b0;
    localparam logic CHAN_RIGHT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // input request taken this cycle
        logic div_load;  // latch dividend and divisor
        logic div_step;  // one restoring divide step
        logic out_load;  // move quotient into output register
    } t_adm_cmd;

    // datapath to controller status
    typedef struct packed {
        logic fire;      // current sample closes a group and yields a result
    } t_adm_status;

endpackage

// ===== rtl/core/adm_ctrl.sv =====
// ----------------------------------------------------------------------------
// adm_ctrl
// Controller: input/output handshake, divide step counter, output valid.
// ----------------------------------------------------------------------------
module adm_ctrl
    import adm_pkg::*;
#(
    parameter int STEPS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    input  t_adm_status i_status,
    output t_adm_cmd    o_cmd
);

    localparam int CNT_W = $clog2(STEPS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;

    // commands
    always_comb begin
        o_stall         = (r_state != S_IDLE);
        o_cmd.accept    = (r_state == S_IDLE) && i_valid;
        o_cmd.div_load  = o_cmd.accept && i_status.fire;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_HOLD) && (!r_valid || !i_stall);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.div_load) begin
                    n_state = S_DIV;
                    n_cnt   = CNT_W'(STEPS);
                end
            end
            S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (o_cmd.out_load) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== rtl/core/adm_dp.sv =====
// ----------------------------------------------------------------------------
// adm_dp
// Datapath: config registers, channel/frame position, group sums, serial
// restoring divider and output payload register.
// ----------------------------------------------------------------------------
module adm_dp
    import adm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_adm_cmd                   i_cmd,
    output t_adm_status                o_status,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic                       o_out_channel
);

    // sum covers 4 frames of MAX_CHANNELS samples
    localparam int SUM_W = SAMPLE_W + $clog2(4 * MAX_CHANNELS);
    localparam int DVS_W = $clog2(4 * MAX_CHANNELS + 1);
    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // config registers
    logic [CFG_W-1:0] r_rate_req;
    logic [CFG_W-1:0] r_chan_cnt;
    logic             r_mono_req;

    // group state
    logic signed [SUM_W-1:0] r_sum_left, r_sum_right;
    logic [POS_W-1:0]        r_pos;
    logic [1:0]              r_frame;

    // divider state
    logic [SUM_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_divisor;
    logic             r_neg;
    logic             r_chan;

    // effective settings
    logic [2:0]       eff_div;
    logic [1:0]       div_shift;
    logic [CFG_W-1:0] eff_ch;
    logic             mono;
    logic             last_frame;
    logic             last_chan;
    logic             at_left, at_right;

    always_comb begin
        if (r_rate_req == RATE_DIV2) begin
            eff_div   = 3'd2;
            div_shift = 2'd1;
        end else if (r_rate_req == RATE_DIV4) begin
            eff_div   = 3'd4;
            div_shift = 2'd2;
        end else begin
            eff_div   = 3'd1;
            div_shift = 2'd0;
        end
        // channel_count never exceeds 15, so a saturated value fits CFG_W
        if (r_chan_cnt == '0) begin
            eff_ch = CFG_W'(1);
        end else if (int'(r_chan_cnt) > MAX_CHANNELS) begin
            eff_ch = CFG_W'(MAX_CHANNELS);
        end else begin
            eff_ch = r_chan_cnt;
        end
        mono       = r_mono_req || (eff_ch == CFG_W'(1));
        last_frame = ({1'b0, r_frame} == (eff_div - 3'd1));
        last_chan  = (CFG_W'(r_pos) == (eff_ch - CFG_W'(1)));
        at_left    = (r_pos == POS_W'(0));
        at_right   = (r_pos == POS_W'(1));
    end

    // accumulate and detect group end
    logic signed [SUM_W-1:0] s_ext;
    logic signed [SUM_W-1:0] add_left, add_right;
    logic signed [SUM_W-1:0] dividend;
    logic [SUM_W-1:0]        dividend_mag;
    logic [DVS_W-1:0]        divisor;
    logic                    res_chan;

    always_comb begin
        s_ext     = SUM_W'(i_sample);
        add_left  = r_sum_left + s_ext;
        add_right = r_sum_right + s_ext;
        o_status.fire = 1'b0;
        dividend  = add_left;
        res_chan  = CHAN_LEFT;
        divisor   = DVS_W'(eff_div);
        if (mono) begin
            o_status.fire = last_frame && last_chan;
            divisor       = DVS_W'(eff_ch) << div_shift;
        end else if (at_left) begin
            o_status.fire = last_frame;
        end else if (at_right) begin
            o_status.fire = last_frame;
            dividend      = add_right;
            res_chan      = CHAN_RIGHT;
        end
        dividend_mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    end

    // position advance
    logic [CFG_W-1:0] pos_inc;
    logic [2:0]       frame_inc;

    assign pos_inc   = CFG_W'(r_pos) + CFG_W'(1);
    assign frame_inc = {1'b0, r_frame} + 3'd1;

    // config, sums and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_req  <= RATE_RESET;
            r_chan_cnt  <= CHAN_RESET;
            r_mono_req  <= 1'b0;
            r_sum_left  <= '0;
            r_sum_right <= '0;
            r_pos       <= '0;
            r_frame     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RATE_DIVIDE: r_rate_req <= i_cfg_data;
                REG_CHAN_COUNT:  r_chan_cnt <= i_cfg_data;
                REG_MONO:        r_mono_req <= i_cfg_data[0];
                default: ;
            endcase
            r_sum_left  <= '0;
            r_sum_right <= '0;
            r_pos       <= '0;
            r_frame     <= '0;
        end else if (i_cmd.accept) begin
            if (mono || at_left) begin
                r_sum_left <= o_status.fire ? '0 : add_left;
            end else if (at_right) begin
                r_sum_right <= o_status.fire ? '0 : add_right;
            end
            if (pos_inc >= eff_ch) begin
                r_pos <= '0;
                if (frame_inc >= eff_div) begin
                    r_frame <= '0;
                end else begin
                    r_frame <= frame_inc[1:0];
                end
            end else begin
                r_pos <= POS_W'(pos_inc);
            end
        end
    end

    // restoring divide step on magnitudes
    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] rem_sub;
    logic           q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_divisor};
        q_bit   = (rem_sh >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo     <= dividend_mag;
            r_rem     <= '0;
            r_divisor <= divisor;
            r_neg     <= dividend[SUM_W-1];
            r_chan    <= res_chan;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    // output payload, sign restored (truncation toward zero)
    logic [SUM_W-1:0] quo_signed;

    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_average     <= quo_signed[SAMPLE_W-1:0];
            o_out_channel <= r_chan;
        end
    end

endmodule

// ===== rtl/core/averaging_decimator_downmix.sv =====
// An item with no result is taken without a stall. An item that closes a
// group loads the bit-serial restoring divider, which steps in S_DIV; the
// quotient then waits in S_HOLD until the output register is free.
// Throughput: 1 item per cycle between group ends; input stalls from a group
// end until its result is loaded. Reset (synchronous, active low) restores
// default settings and clears sums, position and the output register valid.
// ----------------------------------------------------------------------------
// averaging_decimator_downmix
// Boxcar averaging decimator with optional mono downmix of interleaved
// signed 16-bit samples.
// ----------------------------------------------------------------------------
module averaging_decimator_downmix
    import adm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic                       o_out_channel
);

    localparam int SUM_W = SAMPLE_W + $clog2(4 * MAX_CHANNELS);

    t_adm_cmd    cmd;
    t_adm_status status;

    // controller
    adm_ctrl #(
        .STEPS (SUM_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    adm_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_average     (o_average),
        .o_out_channel (o_out_channel)
    );

endmodule

// ===== tb/averaging_decimator_downmix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// averaging_decimator_downmix_checker
// Watches the register port and both request channels of the decimator. It
// keeps its own copy of the settings, sums and frame position, works out
// each expected average, and compares every accepted output against it.
// ----------------------------------------------------------------------------
module averaging_decimator_downmix_checker
    import adm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] i_average,
    input  logic                       i_out_channel,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);

    // sum covers 4 frames of MAX_CHANNELS samples
    localparam int SUM_W = SAMPLE_W + $clog2(4 * MAX_CHANNELS);
    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       out_channel;
    } t_avg_result;

    // predicted output requests, oldest first
    t_avg_result averages_due[$];

    // settings mirror
    logic [CFG_W-1:0] rate_req;
    logic [CFG_W-1:0] chan_req;
    logic             mono_req;

    // accumulation state mirror
    logic signed [SUM_W-1:0] left_sum;
    logic signed [SUM_W-1:0] right_sum;
    logic [POS_W-1:0]        chan_pos;
    logic [1:0]              frame_idx;

    int error_count  = 0;
    int pending_count = 0;
    int result_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_results = result_count;

    // any write, even to a spare index, starts a fresh group
    task automatic restart_group();
        left_sum  = '0;
        right_sum = '0;
        chan_pos  = '0;
        frame_idx = '0;
    endtask

    // fold one sample into the sums; queue an average when a group closes
    task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s);
        int  div;
        int  nch;
        int  pos;
        int  quotient;
        logic mono;
        logic closes;
        div = (rate_req == RATE_DIV2 || rate_req == RATE_DIV4) ? int'(rate_req) : 1;
        if (chan_req == 0)
            nch = 1;
        else if (chan_req > MAX_CHANNELS)
            nch = MAX_CHANNELS;
        else
            nch = int'(chan_req);
        mono   = mono_req || (nch == 1);
        pos    = int'(chan_pos);
        closes = (int'(frame_idx) == div - 1);

        if (mono) begin
            left_sum = left_sum + s;
            if (closes && pos == nch - 1) begin
                quotient = int'(left_sum) / (div * nch);
                averages_due.push_back('{average: quotient[SAMPLE_W-1:0],
                                         out_channel: CHAN_LEFT});
                left_sum = '0;
            end
        end else if (pos == 0) begin
            left_sum = left_sum + s;
            if (closes) begin
                quotient = int'(left_sum) / div;
                averages_due.push_back('{average: quotient[SAMPLE_W-1:0],
                                         out_channel: CHAN_LEFT});
                left_sum = '0;
            end
        end else if (pos == 1) begin
            right_sum = right_sum + s;
            if (closes) begin
                quotient = int'(right_sum) / div;
                averages_due.push_back('{average: quotient[SAMPLE_W-1:0],
                                         out_channel: CHAN_RIGHT});
                right_sum = '0;
            end
        end
        // channels 2 and up in stereo mode only move the position

        pos++;
        if (pos >= nch) begin
            pos = 0;
            if (int'(frame_idx) + 1 >= div)
                frame_idx = '0;
            else
                frame_idx = frame_idx + 1'b1;
        end
        chan_pos = pos[POS_W-1:0];
    endtask

    // compare one output request against the oldest prediction
    task automatic check_average();
        t_avg_result want;
        result_count++;
        if (averages_due.size() == 0) begin
            $error("unexpected output: average %0d out_channel %0d",
                   i_average, i_out_channel);
            error_count++;
        end else begin
            want = averages_due.pop_front();
            if (want.average !== i_average) begin
                $error("average: expected %0d, actual %0d", want.average, i_average);
                error_count++;
            end
            if (want.out_channel !== i_out_channel) begin
                $error("out_channel: expected %0d, actual %0d",
                       want.out_channel, i_out_channel);
                error_count++;
            end
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_req = RATE_RESET;
            chan_req = CHAN_RESET;
            mono_req = 1'b0;
            restart_group();
            averages_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RATE_DIVIDE: rate_req = i_cfg_data;
                    REG_CHAN_COUNT:  chan_req = i_cfg_data;
                    REG_MONO:        mono_req = i_cfg_data[0];
                    default: ;
                endcase
                restart_group();
            end
            if (i_in_valid && !i_in_stall)
                accumulate_sample(i_sample);
            if (i_out_valid && !i_out_stall)
                check_average();
        end
        pending_count = averages_due.size();
    end

endmodule

// ===== tb/averaging_decimator_downmix_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// averaging_decimator_downmix_test
// Stimulus and verdict for the averaging decimator. A directed opening hits
// full-scale samples, truncation toward zero, one-channel mono and a group
// restart by a spare register write; random phases then sweep many register
// settings with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module averaging_decimator_downmix_test;
    import adm_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 14;
    localparam int HOLD_PHASE    = 2;
    localparam int STEADY_PHASE  = 5;

    // index past the register list: changes nothing but restarts the group
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] average;
    logic                       out_channel;

    int errors;
    int pending;
    int results;

    int cycle_count    = 0;
    int samples_sent   = 0;
    int settings_count = 0;

    // traffic shaping flags shared with the receiver
    logic tx_steady    = 1'b0;
    logic rx_steady    = 1'b0;
    logic hold_off_req = 1'b0;

    averaging_decimator_downmix uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_sample      (sample),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_average     (average),
        .o_out_channel (out_channel)
    );

    averaging_decimator_downmix_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_sample      (sample),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_average     (average),
        .i_out_channel (out_channel),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results)
    );

    // clock
    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin : receiver
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= !rx_steady && ($urandom_range(99) < 22);
            end
        end
    end

    // offer one sample and hold it until taken; sometimes idle afterward
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        samples_sent++;
        if (!tx_steady && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted average has come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits of the mono write are don't-care and get random values
    task automatic write_settings(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] chans,
                                  input logic mono);
        write_reg(REG_RATE_DIVIDE, rate);
        write_reg(REG_CHAN_COUNT, chans);
        write_reg(REG_MONO, {3'($urandom_range(7)), mono});
        settings_count++;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0]           rate_set;
        logic [CFG_W-1:0]           chan_set;
        logic                       mono_set;
        logic signed [SAMPLE_W-1:0] s;
        int                         n_items;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stereo, no decimation, full-scale both ways
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd0);
        send_sample(-16'sd1);

        // one channel forces mono; divide by 4 at both rails
        wait_drain();
        write_settings(RATE_DIV4, 4'd1, 1'b0);
        repeat (4) send_sample(16'sh8000);
        repeat (4) send_sample(16'sh7FFF);

        // mono fold of 3 channels over 2 frames: -2/6 truncates to zero
        wait_drain();
        write_settings(RATE_DIV2, 4'd3, 1'b1);
        send_sample(-16'sd1);
        send_sample(-16'sd1);
        repeat (4) send_sample(16'sd0);

        // spare-index write drops a partial group, then stereo truncation
        wait_drain();
        write_settings(RATE_DIV2, 4'd2, 1'b0);
        send_sample(16'sd12345);
        wait_drain();
        write_reg(REG_SPARE, 4'hF);
        send_sample(-16'sd3);
        send_sample(16'sd3);
        send_sample(16'sd0);
        send_sample(-16'sd2);

        // random phases over a sweep of settings
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            wait_drain();
            case (k)
                0:  begin rate_set = 4'd0;      chan_set = 4'd0;  mono_set = 1'b0; end
                1:  begin rate_set = 4'd15;     chan_set = 4'd15; mono_set = 1'b1; end
                2:  begin rate_set = RATE_RESET; chan_set = 4'd1; mono_set = 1'b0; end
                3:  begin rate_set = RATE_DIV4; chan_set = 4'd8;  mono_set = 1'b0; end
                4:  begin rate_set = RATE_DIV4; chan_set = 4'd8;  mono_set = 1'b1; end
                5:  begin rate_set = RATE_DIV2; chan_set = 4'd2;  mono_set = 1'b0; end
                6:  begin rate_set = 4'd3;      chan_set = 4'd5;  mono_set = 1'b0; end
                7:  begin rate_set = RATE_DIV2; chan_set = 4'd9;  mono_set = 1'b0; end
                8:  begin rate_set = RATE_DIV4; chan_set = 4'd1;  mono_set = 1'b0; end
                9:  begin rate_set = RATE_DIV2; chan_set = 4'd7;  mono_set = 1'b1; end
                default: begin
                    case ($urandom_range(3))
                        0:       rate_set = RATE_DIV2;
                        1:       rate_set = RATE_DIV4;
                        default: rate_set = 4'($urandom_range(15));
                    endcase
                    chan_set = 4'($urandom_range(15));
                    mono_set = 1'($urandom_range(1));
                end
            endcase
            if ($urandom_range(3) == 0)
                write_reg(REG_SPARE, 4'($urandom_range(15)));
            write_settings(rate_set, chan_set, mono_set);

            tx_steady = (k == STEADY_PHASE);
            rx_steady = (k == STEADY_PHASE);
            // every sample yields an average here, so the block backs up fast
            if (k == HOLD_PHASE)
                hold_off_req = 1'b1;

            n_items = $urandom_range(110, 140);
            for (int i = 0; i < n_items; i++) begin
                // pause mid-phase and restart the group with a spare write
                if (k % 4 == 1 && i == n_items / 2) begin
                    wait_drain();
                    write_reg(REG_SPARE, 4'($urandom_range(15)));
                end
                case ($urandom_range(9))
                    0:       s = 16'sh8000;
                    1:       s = 16'sh7FFF;
                    2:       s = SAMPLE_W'($signed($urandom_range(7)) - 4);
                    default: s = SAMPLE_W'($urandom_range(16'hFFFF));
                endcase
                send_sample(s);
            end
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drain();

        $display("Run covered %0d samples under %0d register settings, %0d averages checked,",
                 samples_sent, settings_count, results);
        $display("with random idling on both channels and one long output hold-off.");
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== averaging_decimator_downmix.f =====
rtl/core/adm_pkg.sv
rtl/core/adm_ctrl.sv
rtl/core/adm_dp.sv
rtl/core/averaging_decimator_downmix.sv
tb/averaging_decimator_downmix_checker.sv
tb/averaging_decimator_downmix_test.sv
